### hw/rtl/ddf_pkg.sv
// Shared types and constants for the decimal digit display formatter.
// Used by every module under hw/rtl; depends on nothing.
package ddf_pkg;

  localparam int NumWrites = 8;
  localparam int IdxW      = $clog2(NumWrites);

  localparam logic [13:0] LEFT_LIMIT = 14'd9999;
  localparam logic [6:0]  PAIR_LIMIT = 7'd99;
  localparam logic [7:0]  CODE_BLANK = 8'h0F;
  localparam logic [7:0]  CODE_DP    = 8'h80;
  localparam logic [3:0]  LEFT_BASE  = 4'h5;
  localparam logic [3:0]  FEET_BASE  = 4'h3;
  localparam logic [3:0]  INCH_BASE  = 4'h1;
  localparam logic [IdxW-1:0] IDX_LAST = IdxW'(NumWrites - 1);

  // Reciprocal multipliers for division by constants
  localparam logic [15:0] RECIP_10_L   = 16'd52429;  // >> 19, 14-bit operand
  localparam logic [12:0] RECIP_100_L  = 13'd5243;   // >> 19, 14-bit operand
  localparam logic [14:0] RECIP_1000_L = 15'd16778;  // >> 24, 14-bit operand
  localparam logic [7:0]  RECIP_10_P   = 8'd205;     // >> 11, 7-bit operand

  // Quotients of the three groups, registered after the first stage
  typedef struct packed {
    logic [13:0] left;
    logic [10:0] left_q1;
    logic [7:0]  left_q2;
    logic [4:0]  left_q3;
    logic        left_show;
    logic [6:0]  feet;
    logic [3:0]  feet_q1;
    logic        feet_show;
    logic [6:0]  inch;
    logic [3:0]  inch_q1;
    logic        inch_show;
  } quot_t;

  typedef logic [NumWrites-1:0][7:0] code_buf_t;

  // Digit address for each slot of the write sequence
  function automatic logic [3:0] slot_addr(input logic [IdxW-1:0] idx);
    logic [3:0] addr;
    case (idx)
      3'd0:    addr = LEFT_BASE;
      3'd1:    addr = LEFT_BASE + 4'd1;
      3'd2:    addr = LEFT_BASE + 4'd2;
      3'd3:    addr = LEFT_BASE + 4'd3;
      3'd4:    addr = FEET_BASE;
      3'd5:    addr = FEET_BASE + 4'd1;
      3'd6:    addr = INCH_BASE;
      default: addr = INCH_BASE + 4'd1;
    endcase
    return addr;
  endfunction

endpackage

### hw/rtl/ddf_quot.sv
// First stage: registers one transaction and the decimal quotients of its values.
// Depends on ddf_pkg.
module ddf_quot import ddf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        drain,
  input  logic [13:0] left_value,
  input  logic [6:0]  feet_value,
  input  logic [6:0]  inch_value,
  output quot_t       q,
  output logic        full
);

  logic [29:0] prod_l10;
  logic [26:0] prod_l100;
  logic [28:0] prod_l1000;
  logic [14:0] prod_f10;
  logic [14:0] prod_i10;
  quot_t       q_next;

  // Divide by constants through reciprocal multiplication
  always_comb begin
    prod_l10   = {16'd0, left_value} * {14'd0, RECIP_10_L};
    prod_l100  = {13'd0, left_value} * {14'd0, RECIP_100_L};
    prod_l1000 = {15'd0, left_value} * {14'd0, RECIP_1000_L};
    prod_f10   = {8'd0, feet_value} * {7'd0, RECIP_10_P};
    prod_i10   = {8'd0, inch_value} * {7'd0, RECIP_10_P};

    q_next.left      = left_value;
    q_next.left_q1   = prod_l10[29:19];
    q_next.left_q2   = prod_l100[26:19];
    q_next.left_q3   = prod_l1000[28:24];
    q_next.left_show = (left_value != 14'd0) && (left_value <= LEFT_LIMIT);
    q_next.feet      = feet_value;
    q_next.feet_q1   = prod_f10[14:11];
    q_next.feet_show = (feet_value != 7'd0) && (feet_value <= PAIR_LIMIT);
    q_next.inch      = inch_value;
    q_next.inch_q1   = prod_i10[14:11];
    q_next.inch_show = (inch_value != 7'd0) && (inch_value <= PAIR_LIMIT);
  end

  // Track occupancy of the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (drain) begin
      full <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      q <= q_next;
    end
  end

endmodule

### hw/rtl/ddf_code.sv
// Second stage: turns quotients into eight Code B bytes in write order.
// Depends on ddf_pkg.
module ddf_code import ddf_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  quot_t     q,
  output code_buf_t codes
);

  logic [14:0] l_ten1;
  logic [10:0] l_ten2;
  logic [7:0]  l_ten3;
  logic [6:0]  f_ten;
  logic [6:0]  i_ten;
  logic [14:0] l_d0;
  logic [10:0] l_d1;
  logic [7:0]  l_d2;
  logic [6:0]  f_d0;
  logic [6:0]  i_d0;
  code_buf_t   codes_next;

  // Ten times the first quotient of the big value
  function automatic logic [14:0] l_ten1_src(input logic [10:0] v);
    return {1'b0, v, 3'd0} + {3'd0, v, 1'b0};
  endfunction

  always_comb begin
    // Remainders: value minus ten times its quotient
    l_ten1 = {l_ten1_src(q.left_q1)};
    l_ten2 = {q.left_q2, 3'd0} + {2'd0, q.left_q2, 1'b0};
    l_ten3 = {q.left_q3, 3'd0} + {2'd0, q.left_q3, 1'b0};
    f_ten  = {q.feet_q1, 3'd0} + {2'd0, q.feet_q1, 1'b0};
    i_ten  = {q.inch_q1, 3'd0} + {2'd0, q.inch_q1, 1'b0};
    l_d0   = {1'b0, q.left} - l_ten1;
    l_d1   = q.left_q1 - l_ten2;
    l_d2   = q.left_q2 - l_ten3;
    f_d0   = q.feet - f_ten;
    i_d0   = q.inch - i_ten;

    // Show a digit only while the value reaches its position
    codes_next[0] = q.left_show ? {4'd0, l_d0[3:0]} : CODE_BLANK;
    codes_next[1] = (q.left_show && q.left_q1 != 11'd0) ? {4'd0, l_d1[3:0]} : CODE_BLANK;
    codes_next[2] = (q.left_show && q.left_q2 != 8'd0) ? {4'd0, l_d2[3:0]} : CODE_BLANK;
    codes_next[3] = (q.left_show && q.left_q3 != 5'd0) ? {4'd0, q.left_q3[3:0]}
                                                       : CODE_BLANK;
    codes_next[4] = q.feet_show ? (CODE_DP | {4'd0, f_d0[3:0]}) : CODE_BLANK;
    codes_next[5] = (q.feet_show && q.feet_q1 != 4'd0) ? {4'd0, q.feet_q1} : CODE_BLANK;
    codes_next[6] = q.inch_show ? {4'd0, i_d0[3:0]} : CODE_BLANK;
    codes_next[7] = (q.inch_show && q.inch_q1 != 4'd0) ? {4'd0, q.inch_q1} : CODE_BLANK;
  end

  // Hold the codes for the serializer
  always_ff @(posedge clk) begin
    if (load) begin
      codes <= codes_next;
    end
  end

endmodule

### hw/rtl/ddf_serial.sv
// Output stage: walks the eight buffered codes, one write per transaction.
// Depends on ddf_pkg.
module ddf_serial import ddf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  code_buf_t codes,
  input  logic      out_stall,
  output logic      out_valid,
  output logic      free,
  output logic [3:0] digit_addr,
  output logic [7:0] seg_code,
  output logic      last
);

  logic [IdxW-1:0] idx;
  logic            full;
  logic            take;

  assign take      = full && !out_stall;
  assign free      = !full || (take && idx == IDX_LAST);
  assign out_valid = full;

  // Advance through the sequence, restart on a new run
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (idx == IDX_LAST) begin
        full <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Select the current write
  assign digit_addr = slot_addr(idx);
  assign seg_code   = codes[idx];
  assign last       = (idx == IDX_LAST);

  a_idx_zero_at_load: assert property (@(posedge clk) disable iff (rst)
    load |=> (idx == '0) && full)
    else $error("run does not start at first slot");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (take && !last && !load) |=> full && (idx == $past(idx) + 1'b1))
    else $error("sequence did not advance by one");

endmodule

### hw/rtl/decimal_digit_display_formatter.sv
// Top level of the decimal digit display formatter.
// Depends on ddf_pkg, ddf_quot, ddf_code and ddf_serial.
//
// Each input transaction carries a four-digit value, a feet value and an inch
// value and produces exactly eight digit-register writes on the output
// channel, one per cycle unless out_stall holds them: addresses 5..8 for the
// big value, 3..4 for feet, 1..2 for inches, least significant digit first.
// Unused leading digits, zero values and values over 9999 or 99 show blank
// (0x0F); a shown digit at address 3 carries the decimal point. An accepted
// input is registered in ddf_quot, then its codes in ddf_code as ddf_serial
// starts the run; the sustained rate is set by the single output channel.
// One input transaction can be held ahead of the output run, so the input
// is accepted while earlier writes are still waiting to be taken.
module decimal_digit_display_formatter import ddf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] left_value,
  input  logic [6:0]  feet_value,
  input  logic [6:0]  inch_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  digit_addr,
  output logic [7:0]  seg_code,
  output logic        last
);

  quot_t     q;
  code_buf_t codes;
  logic      q_full;
  logic      ser_free;
  logic      in_load;
  logic      q_drain;

  // Pipeline handshake
  assign q_drain  = q_full && ser_free;
  assign in_stall = q_full && !ser_free;
  assign in_load  = in_valid && !in_stall;

  ddf_quot u_quot (
    .clk        (clk),
    .rst        (rst),
    .load       (in_load),
    .drain      (q_drain),
    .left_value (left_value),
    .feet_value (feet_value),
    .inch_value (inch_value),
    .q          (q),
    .full       (q_full)
  );

  ddf_code u_code (
    .clk   (clk),
    .load  (q_drain),
    .q     (q),
    .codes (codes)
  );

  ddf_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load       (q_drain),
    .codes      (codes),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .free       (ser_free),
    .digit_addr (digit_addr),
    .seg_code   (seg_code),
    .last       (last)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full && out_valid)
    else $error("input stalled with room in the pipeline");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_load |=> q_full)
    else $error("accepted transaction was lost");

  a_last_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (digit_addr == INCH_BASE + 4'd1))
    else $error("final write at wrong address");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("run ended before the final write");

endmodule

### tb/ddf_tb_pkg.sv
// Scoreboard for the decimal digit display formatter testbench.
// Depends on ddf_pkg for the limits, base addresses and digit codes.
package ddf_tb_pkg;
  import ddf_pkg::*;

  // Digit address that carries the decimal point when a digit is shown
  localparam logic [3:0] DP_ADDR = 4'd3;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] code;
    logic       last;
  } digit_write_t;

  class display_write_tracker;
    digit_write_t due_writes[$];
    int unsigned  readings_seen;
    int unsigned  writes_checked;
    int unsigned  mismatches;

    // Print one line per problem and count it
    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Queue the digit writes of one group, least significant digit first
    function void predict_group(int unsigned value, int unsigned limit,
                                logic [3:0] base, int unsigned count, bit closes);
      int unsigned  rest;
      int unsigned  i;
      digit_write_t w;
      rest = (value > 0 && value <= limit) ? value : 0;
      for (i = 0; i < count; i++) begin
        w.addr = base + 4'(i);
        w.last = closes && (i == count - 1);
        if (rest > 0) begin
          w.code = 8'(rest % 10);
          rest   = rest / 10;
          if (w.addr == DP_ADDR) begin
            w.code = w.code | CODE_DP;
          end
        end else begin
          w.code = CODE_BLANK;
        end
        due_writes.push_back(w);
      end
    endfunction

    // Note one accepted input transaction: eight writes fall due
    function void take_reading(logic [13:0] left, logic [6:0] feet, logic [6:0] inch);
      readings_seen++;
      predict_group(left, LEFT_LIMIT, LEFT_BASE, 4, 1'b0);
      predict_group(feet, PAIR_LIMIT, FEET_BASE, 2, 1'b0);
      predict_group(inch, PAIR_LIMIT, INCH_BASE, 2, 1'b1);
    endfunction

    // Compare one accepted output transaction with the oldest due write
    task check_write(logic [3:0] addr, logic [7:0] code, logic last);
      digit_write_t w;
      if (due_writes.size() == 0) begin
        report($sformatf("write addr %0d code 0x%02h with nothing due", addr, code));
      end else begin
        w = due_writes.pop_front();
        writes_checked++;
        if (addr !== w.addr) begin
          report($sformatf("digit_addr %0d, expected %0d", addr, w.addr));
        end
        if (code !== w.code) begin
          report($sformatf("seg_code 0x%02h at addr %0d, expected 0x%02h",
                           code, w.addr, w.code));
        end
        if (last !== w.last) begin
          report($sformatf("last %0b at addr %0d, expected %0b", last, w.addr, w.last));
        end
      end
    endtask

    function int unsigned pending();
      return due_writes.size();
    endfunction
  endclass

endpackage

### tb/testbench.sv
// Top-level testbench for decimal_digit_display_formatter.
// Depends on ddf_pkg and ddf_tb_pkg; drives directed then random readings
// with bursty input, a stalling receiver and one long output hold-off.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ddf_pkg::*;
  import ddf_tb_pkg::*;

  localparam int unsigned RANDOM_READINGS = 350;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [13:0] left_value = '0;
  logic [6:0]  feet_value = '0;
  logic [6:0]  inch_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  digit_addr;
  logic [7:0]  seg_code;
  logic        last;

  display_write_tracker tracker = new();
  int unsigned cycles;
  int unsigned directed_count;
  bit          hold_request;
  bit          hold_done;

  decimal_digit_display_formatter i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_value (left_value),
    .feet_value (feet_value),
    .inch_value (inch_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_addr (digit_addr),
    .seg_code   (seg_code),
    .last       (last)
  );

  always #6 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d writes still due", cycles, tracker.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Watch both channels for accepted transactions
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      tracker.take_reading(left_value, feet_value, inch_value);
    end
    if (!rst && out_valid && !out_stall) begin
      tracker.check_write(digit_addr, seg_code, last);
    end
  end

  // Offer one reading and hold it until the block takes it
  task offer_reading(logic [13:0] left, logic [6:0] feet, logic [6:0] inch);
    in_valid   <= 1'b1;
    left_value <= left;
    feet_value <= feet;
    inch_value <= inch;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Drop valid for a random number of cycles
  task idle_sender(int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [13:0] pick_left();
    case ($urandom_range(9, 0))
      0:       return 14'd0;
      1:       return 14'($urandom_range(16383, 10000));
      2:       return 14'($urandom_range(9, 1));
      3:       return 14'($urandom_range(99, 10));
      4:       return 14'($urandom_range(999, 100));
      5, 6:    return 14'($urandom_range(9999, 1000));
      default: return 14'($urandom_range(16383, 0));
    endcase
  endfunction

  function automatic logic [6:0] pick_pair();
    case ($urandom_range(7, 0))
      0:       return 7'd0;
      1:       return 7'($urandom_range(127, 100));
      2:       return 7'($urandom_range(9, 1));
      3, 4, 5: return 7'($urandom_range(99, 10));
      default: return 7'($urandom_range(127, 0));
    endcase
  endfunction

  // Receiver: free stretches, random stalls, stall runs, one long hold-off
  initial begin
    int unsigned span;
    int unsigned k;
    forever begin
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      span = $urandom_range(40, 10);
      case ($urandom_range(2, 0))
        0: begin
          for (k = 0; k < span; k++) begin
            out_stall <= 1'b0;
            @(posedge clk);
          end
        end
        1: begin
          for (k = 0; k < span; k++) begin
            out_stall <= ($urandom_range(2, 0) == 0);
            @(posedge clk);
          end
        end
        default: begin
          for (k = 0; k < span; k++) begin
            out_stall <= (k % 8) < 5;
            @(posedge clk);
          end
        end
      endcase
    end
  end

  // Sender: directed readings, then random bursts
  initial begin
    logic [13:0] dir_left[] = '{14'd0, 14'd16383, 14'd1, 14'd9, 14'd10, 14'd99, 14'd100,
                                14'd999, 14'd1000, 14'd9999, 14'd10000, 14'd1005,
                                14'd4321, 14'd2048, 14'd9998, 14'd8191, 14'd7, 14'd10001};
    logic [6:0]  dir_feet[] = '{7'd0, 7'd127, 7'd1, 7'd9, 7'd10, 7'd99, 7'd100,
                                7'd5, 7'd98, 7'd1, 7'd0, 7'd10, 7'd21, 7'd64,
                                7'd100, 7'd127, 7'd0, 7'd42};
    logic [6:0]  dir_inch[] = '{7'd0, 7'd127, 7'd1, 7'd9, 7'd10, 7'd99, 7'd100,
                                7'd50, 7'd7, 7'd99, 7'd127, 7'd3, 7'd12, 7'd64,
                                7'd0, 7'd1, 7'd99, 7'd85};
    int unsigned sent;
    int unsigned burst;
    int unsigned b;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed readings, with a short gap after some of them
    for (b = 0; b < dir_left.size(); b++) begin
      offer_reading(dir_left[b], dir_feet[b], dir_inch[b]);
      idle_sender((b % 3 == 1) ? $urandom_range(3, 1) : 0);
    end
    directed_count = dir_left.size();

    // Random bursts; ask the receiver for its long hold-off early on
    hold_request = 1'b1;
    sent = 0;
    while (sent < RANDOM_READINGS) begin
      burst = $urandom_range(16, 1);
      for (b = 0; b < burst && sent < RANDOM_READINGS; b++) begin
        offer_reading(pick_left(), pick_pair(), pick_pair());
        sent++;
      end
      idle_sender(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1));
    end
    in_valid <= 1'b0;

    // Wait for every due write, then watch for strays
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d readings (%0d directed) and %0d digit writes, including a %0d-cycle",
             tracker.readings_seen, directed_count, tracker.writes_checked, LONG_HOLD);
    $display("output hold-off with the input backed up; %0d mismatches", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
